FILE: design/appp_pkg.sv
package appp_pkg;

  localparam int RANKS       = 2;
  localparam int QUEUES      = 32;
  localparam int COUNT_WIDTH = 16;

  localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  // raw queue index: rank base + group offset + bank,
  // and the end of a rank's bank range
  localparam int QRAW_W = 8;

  localparam int PADDR_W = 5;
  localparam int DATA_W  = 32;

  localparam logic [QRAW_W-1:0] QUEUES_RAW = QRAW_W'(QUEUES);
  localparam logic [QRAW_W-1:0] RANKS_RAW  = QRAW_W'(RANKS);

  // counter saturation value
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // register indexes
  localparam logic [2:0] REG_BASE_POLICY     = 3'd0;
  localparam logic [2:0] REG_EPOCH_TICKS     = 3'd1;
  localparam logic [2:0] REG_PER_RANK_MODE   = 3'd2;
  localparam logic [2:0] REG_BANKS_PER_RANK  = 3'd3;
  localparam logic [2:0] REG_BANKS_PER_GROUP = 3'd4;

  // actions
  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_COUNT    = 3'd1;
  localparam logic [2:0] ACT_REF_ALL  = 3'd2;
  localparam logic [2:0] ACT_REF_BANK = 3'd3;
  localparam logic [2:0] ACT_COLUMN   = 3'd4;

  // policies
  localparam logic [1:0] POL_CLOSE    = 2'd0;
  localparam logic [1:0] POL_OPEN     = 2'd1;
  localparam logic [1:0] POL_SMART    = 2'd2;
  localparam logic [1:0] POL_ADAPTIVE = 2'd3;

  typedef struct packed {
    logic [2:0] action;
    logic       rank;
    logic [1:0] bankgroup;
    logic [1:0] bank;
    logic       add_total;
    logic       add_hit;
    logic       cluster_end;
  } in_t;

  typedef struct packed {
    logic [4:0] queue_index;
    logic [1:0] policy;
    logic [1:0] confidence;
    logic       auto_precharge;
    logic       epoch_done;
  } out_t;

  typedef enum logic [2:0] {
    SOP_NONE,
    SOP_COUNT,
    SOP_CLR_ONE,
    SOP_CLR_RANGE,
    SOP_ARB_WR
  } store_op_t;

  typedef struct packed {
    store_op_t         op;
    logic [QIDX_W-1:0] idx;
    logic              add_total;
    logic              add_hit;
    logic [QRAW_W-1:0] lo;
    logic [QRAW_W-1:0] hi;
    logic [1:0]        conf;
    logic              flag;
  } store_cmd_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] hit;
    logic [COUNT_WIDTH-1:0] total;
    logic [1:0]             conf;
    logic                   flag;
  } entry_t;

endpackage

FILE: design/adaptive_page_policy_predictor.sv
// Sequence: a word is accepted in idle, worked on in the execute state, and its
//   result is registered from the push state; a tick that starts a policy pass
//   first walks each active queue (RANKS in per-rank mode, else RANKS times the
//   rank's bank count, never more than QUEUES).
// Flow: no new word is taken before the last result is registered.
// Reset: synchronous, rst_n low; all entries reset at once (counts cleared, confidence 3), ready right after.
module adaptive_page_policy_predictor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  appp_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output appp_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [appp_pkg::PADDR_W-1:0]  paddr,
  input  logic [appp_pkg::DATA_W-1:0]   pwdata,
  output logic [appp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import appp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WALK = 4'b0100,
    ST_PUSH = 4'b1000
  } state_t;

  // ---------------- configuration registers ----------------
  logic [1:0]  base_r;
  logic [15:0] epoch_r;
  logic        prm_r;
  logic [4:0]  bpr_r;
  logic [2:0]  bpg_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= POL_ADAPTIVE;
      epoch_r <= 16'd1000;
      prm_r   <= 1'b0;
      bpr_r   <= 5'd16;
      bpg_r   <= 3'd4;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BASE_POLICY:     base_r  <= pwdata[1:0];
        REG_EPOCH_TICKS:     epoch_r <= pwdata[15:0];
        REG_PER_RANK_MODE:   prm_r   <= pwdata[0];
        REG_BANKS_PER_RANK:  bpr_r   <= pwdata[4:0];
        REG_BANKS_PER_GROUP: bpg_r   <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BASE_POLICY:     prdata = {30'd0, base_r};
      REG_EPOCH_TICKS:     prdata = {16'd0, epoch_r};
      REG_PER_RANK_MODE:   prdata = {31'd0, prm_r};
      REG_BANKS_PER_RANK:  prdata = {27'd0, bpr_r};
      REG_BANKS_PER_GROUP: prdata = {29'd0, bpg_r};
      default:             prdata = '0;
    endcase
  end

  // ---------------- sequencer state ----------------
  state_t            state_r, state_nxt;
  in_t               item_r;
  logic [15:0]       phase_r, phase_nxt;
  logic              pass_r, pass_nxt;
  logic [QRAW_W-1:0] walk_r, walk_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  // queue address of the held word
  logic [QRAW_W-1:0] rank_base;
  logic [QRAW_W-1:0] q_raw;
  logic              q_ok;
  logic [QRAW_W-1:0] n_active;
  logic [QRAW_W-1:0] rpb;
  logic [16:0]       phase_inc;
  logic              wrap;
  logic              walk_last;
  logic              out_free;

  store_cmd_t cmd;
  entry_t     rd;
  logic [1:0] arb_conf;
  logic       arb_flag;
  out_t       res;

  assign rank_base = QRAW_W'(item_r.rank) * QRAW_W'(bpr_r);
  assign q_raw     = prm_r ? QRAW_W'(item_r.rank)
                           : rank_base + QRAW_W'(item_r.bankgroup) * QRAW_W'(bpg_r)
                             + QRAW_W'(item_r.bank);
  assign q_ok      = q_raw < QUEUES_RAW;
  assign rpb       = RANKS_RAW * QRAW_W'(bpr_r);
  assign n_active  = prm_r ? ((RANKS_RAW < QUEUES_RAW) ? RANKS_RAW : QUEUES_RAW)
                           : ((rpb < QUEUES_RAW) ? rpb : QUEUES_RAW);
  assign phase_inc = {1'b0, phase_r} + 17'd1;
  // epoch of zero acts like one
  assign wrap      = phase_inc >= {1'b0, epoch_r};
  assign walk_last = (walk_r + 1'b1) >= n_active;
  assign out_free  = !out_valid_r || !out_stall;

  appp_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rd    (rd)
  );

  appp_arb u_arb (
    .cur      (rd),
    .new_conf (arb_conf),
    .new_flag (arb_flag)
  );

  // store command: walk index during a pass, the word's queue otherwise
  always_comb begin
    cmd           = '0;
    cmd.op        = SOP_NONE;
    cmd.idx       = q_raw[QIDX_W-1:0];
    cmd.add_total = item_r.add_total;
    cmd.add_hit   = item_r.add_hit;
    cmd.lo        = rank_base;
    cmd.hi        = rank_base + QRAW_W'(bpr_r);
    cmd.conf      = arb_conf;
    cmd.flag      = arb_flag;
    case (state_r)
      ST_EXEC: begin
        case (item_r.action)
          ACT_COUNT:    if (q_ok) cmd.op = SOP_COUNT;
          ACT_REF_BANK: if (q_ok) cmd.op = SOP_CLR_ONE;
          ACT_REF_ALL: begin
            if (prm_r) begin
              if (q_ok) cmd.op = SOP_CLR_ONE;
            end else begin
              cmd.op = SOP_CLR_RANGE;
            end
          end
          default: begin
          end
        endcase
      end
      ST_WALK: begin
        cmd.op  = SOP_ARB_WR;
        cmd.idx = walk_r[QIDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // result from the queue's state after the word's update
  always_comb begin
    res             = '0;
    res.queue_index = q_raw[4:0];
    if (base_r != POL_ADAPTIVE) begin
      res.policy = base_r;
    end else if (q_ok) begin
      res.policy = rd.flag ? POL_SMART : POL_OPEN;
    end else begin
      res.policy = POL_CLOSE;
    end
    res.confidence     = q_ok ? rd.conf : 2'd0;
    res.auto_precharge = (item_r.action == ACT_COLUMN) && q_ok &&
                         (res.policy == POL_SMART) && item_r.cluster_end;
    res.epoch_done     = pass_r;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    pass_nxt      = pass_r;
    walk_nxt      = walk_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        pass_nxt  = 1'b0;
        walk_nxt  = '0;
        state_nxt = ST_PUSH;
        if (item_r.action == ACT_TICK) begin
          phase_nxt = wrap ? 16'd0 : phase_inc[15:0];
          if (wrap && base_r == POL_ADAPTIVE) begin
            pass_nxt = 1'b1;
            if (n_active != '0) begin
              state_nxt = ST_WALK;
            end
          end
        end
      end
      ST_WALK: begin
        walk_nxt = walk_r + 1'b1;
        if (walk_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      pass_r      <= 1'b0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pass_r      <= pass_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (state_r == ST_IDLE && in_valid) begin
      item_r <= in_data;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- checks ----------------
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (walk_r < n_active))
    else $error("walk index past active queues");

  a_push_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished word not delivered to output register");

  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.epoch_done && out_r.auto_precharge))
    else $error("pass flag and auto precharge on one word");

  a_pass_adaptive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (pass_r && base_r == POL_ADAPTIVE))
    else $error("queue walk outside adaptive pass");

endmodule

FILE: design/appp_arb.sv
module appp_arb (
  input  appp_pkg::entry_t cur,
  output logic [1:0]       new_conf,
  output logic             new_flag
);
  import appp_pkg::*;

  logic [COUNT_WIDTH+1:0] hit_x4;
  logic [COUNT_WIDTH+1:0] tot_x3;
  logic                   below_qtr;
  logic                   below_half;
  logic                   at_3qtr;
  logic                   forced;
  logic [1:0]             conf_f;

  assign hit_x4     = {cur.hit, 2'b00};
  assign tot_x3     = {1'b0, cur.total, 1'b0} + {2'b00, cur.total};
  assign below_qtr  = cur.hit < (cur.total >> 2);
  assign below_half = cur.hit < (cur.total >> 1);
  assign at_3qtr    = hit_x4 >= tot_x3;

  always_comb begin
    forced = 1'b0;
    conf_f = cur.conf;
    if (!cur.flag) begin
      if (below_qtr) begin
        conf_f = 2'd0;
        forced = 1'b1;
      end
    end else begin
      if (at_3qtr) begin
        conf_f = 2'd3;
        forced = 1'b1;
      end
    end
    if (!forced) begin
      if (below_half) begin
        conf_f = (cur.conf == 2'd0) ? 2'd0 : cur.conf - 2'd1;
      end else begin
        conf_f = (cur.conf == 2'd3) ? 2'd3 : cur.conf + 2'd1;
      end
    end
  end

  assign new_conf = conf_f;
  // open when confident, smart close otherwise
  assign new_flag = (conf_f < 2'd2);

endmodule

FILE: design/appp_store.sv
module appp_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  appp_pkg::store_cmd_t cmd,
  output appp_pkg::entry_t     rd
);
  import appp_pkg::*;

  entry_t ent_r [QUEUES];

  assign rd = ent_r[cmd.idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUES; i++) begin
        ent_r[i].hit   <= '0;
        ent_r[i].total <= '0;
        ent_r[i].conf  <= 2'd3;
        ent_r[i].flag  <= 1'b0;
      end
    end else begin
      case (cmd.op)
        SOP_COUNT: begin
          if (cmd.add_total && ent_r[cmd.idx].total != COUNT_MAX) begin
            ent_r[cmd.idx].total <= ent_r[cmd.idx].total + 1'b1;
          end
          if (cmd.add_hit && ent_r[cmd.idx].hit != COUNT_MAX) begin
            ent_r[cmd.idx].hit <= ent_r[cmd.idx].hit + 1'b1;
          end
        end
        SOP_CLR_ONE: begin
          ent_r[cmd.idx].hit   <= '0;
          ent_r[cmd.idx].total <= '0;
        end
        SOP_CLR_RANGE: begin
          for (int i = 0; i < QUEUES; i++) begin
            if (QRAW_W'(i) >= cmd.lo && QRAW_W'(i) < cmd.hi) begin
              ent_r[i].hit   <= '0;
              ent_r[i].total <= '0;
            end
          end
        end
        SOP_ARB_WR: begin
          ent_r[cmd.idx].conf <= cmd.conf;
          ent_r[cmd.idx].flag <= cmd.flag;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
